// File: src/rtdq_pkg.sv
// Package for the range task dispatch queue.
// Holds request and status codes, the entry layout, the sequencer states and the
// match-unit interface types. No dependencies.
package rtdq_pkg;

    localparam int ID_INPUTS   = 4;
    localparam int MATCH_IDS   = 4;
    localparam int MATCH_LIMIT = (MATCH_IDS < ID_INPUTS) ? MATCH_IDS : ID_INPUTS;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_MATCH = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] next_index;
        logic [31:0] limit;
    } rtdq_entry_t;

    typedef logic [ID_INPUTS-1:0][31:0] rtdq_ids_t;

    typedef struct packed {
        logic        hit;
        logic        last;
        logic [31:0] next_inc;
    } rtdq_eval_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_REFILL,
        ST_RESP
    } rtdq_state_t;

endpackage

// File: src/rtdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rtdq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rtdq_match_unit.sv
// Shared evaluation unit: compares an entry's next index with the match ids,
// decides whether the entry is on its last index and forms the advanced index.
// Depends on rtdq_pkg.
module rtdq_match_unit
    import rtdq_pkg::*;
(
    input  rtdq_entry_t entry,
    input  rtdq_ids_t   ids,
    input  logic [2:0]  id_count,
    output rtdq_eval_t  result
);

    logic        hit;
    logic [32:0] next_plus;

    always_comb
    begin
        hit = 1'b0;
        for (int j = 0; j < ID_INPUTS; j++)
        begin
            if ((3'(j) < id_count) && (ids[j] == entry.next_index))
            begin
                hit = 1'b1;
            end
        end
    end

    // The last-index test is done without wrap, so a reversed range counts as last.
    assign next_plus       = {1'b0, entry.next_index} + 33'd1;
    assign result.hit      = hit;
    assign result.last     = (next_plus >= {1'b0, entry.limit});
    assign result.next_inc = next_plus[31:0];

endmodule

// File: src/range_task_dispatch_queue_core.sv
// Range task dispatch queue, top level.
// Depends on rtdq_pkg, rtdq_ram and rtdq_match_unit.
//
// A ring of range tasks (handle, next index, limit) held in one RAM of QUEUE_DEPTH
// entries, of which at most QUEUE_DEPTH-1 are used. Every request transaction
// yields exactly one response transaction. A push goes through the response
// state to a registered response; a head pop first goes through the pop state,
// because the head entry comes out of the RAM's registered read port before it
// is updated. A match pop walks the ring from the head through the same read
// port, with a read state and a compare state per entry inspected (up to the
// fill level), then a refill state when the hit entry runs out and its slot is
// refilled from the head entry. The request side is ready only while the
// sequencer is idle; a finished response sits in the output register and does
// not block the next request from being accepted. The RAM needs no clearing
// after reset: only entries between head and tail are read.
module range_task_dispatch_queue_core
    import rtdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] task_handle,
    input  logic [31:0] range_start,
    input  logic [31:0] range_end,
    input  logic [2:0]  match_count,
    input  logic [31:0] match_id_a,
    input  logic [31:0] match_id_b,
    input  logic [31:0] match_id_c,
    input  logic [31:0] match_id_d,

    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [15:0] out_handle,
    output logic [31:0] work_index,
    output logic [5:0]  entries_used
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Sequencer and ring pointers.
    rtdq_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] count_reg, count_next;

    // Match scan bookkeeping.
    logic [AW-1:0] scan_ptr_reg, scan_ptr_next;
    logic [AW-1:0] scan_left_reg, scan_left_next;
    logic [AW-1:0] hit_slot_reg, hit_slot_next;
    rtdq_ids_t     ids_reg, ids_next;
    logic [2:0]    n_reg, n_next;

    // Pending result, then the output register.
    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_handle_reg, res_handle_next;
    logic [31:0] res_index_reg, res_index_next;

    logic        rsp_valid_reg, rsp_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] handle_reg, handle_next;
    logic [31:0] index_reg, index_next;
    logic [5:0]  used_reg, used_next;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    rtdq_entry_t   ram_wdata;
    logic [AW-1:0] ram_raddr;
    rtdq_entry_t   ram_rdata;

    rtdq_eval_t    eval;
    logic          accept;
    logic [2:0]    n_sat;
    logic [31:0]   count_wide;

    rtdq_ram #(
        .WIDTH ($bits(rtdq_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One evaluation unit serves both the head pop and every step of the scan.
    rtdq_match_unit u_match (
        .entry    (ram_rdata),
        .ids      (ids_reg),
        .id_count (n_reg),
        .result   (eval)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // Saturate the number of ids to what the block compares.
    assign n_sat = (match_count > 3'(MATCH_LIMIT)) ? 3'(MATCH_LIMIT) : match_count;

    // The fill level is reported in six bits; deeper rings wrap it.
    assign count_wide = 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg   <= scan_ptr_next;
        scan_left_reg  <= scan_left_next;
        hit_slot_reg   <= hit_slot_next;
        ids_reg        <= ids_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_index_reg  <= res_index_next;
        status_reg     <= status_next;
        handle_reg     <= handle_next;
        index_reg      <= index_next;
        used_reg       <= used_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_left_next  = scan_left_reg;
        hit_slot_next   = hit_slot_reg;
        ids_next        = ids_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_index_next  = res_index_reg;

        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        status_next     = status_reg;
        handle_next     = handle_reg;
        index_next      = index_reg;
        used_next       = used_reg;

        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STATUS_EMPTY;
                    res_handle_next = '0;
                    res_index_next  = '0;
                    state_next      = ST_RESP;
                    unique case (req_type)
                        REQ_PUSH:
                        begin
                            if (count_reg == AW'(QUEUE_DEPTH - 1))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we               = 1'b1;
                                ram_waddr            = tail_reg;
                                ram_wdata.handle     = task_handle;
                                ram_wdata.next_index = range_start;
                                ram_wdata.limit      = range_end;
                                tail_next            = ptr_inc(tail_reg);
                                count_next           = count_reg + AW'(1);
                                res_status_next      = STATUS_OK;
                            end
                        end
                        REQ_POP:
                        begin
                            // The read of the head entry is already addressed.
                            if (count_reg != '0)
                            begin
                                state_next = ST_POP;
                            end
                        end
                        REQ_MATCH:
                        begin
                            if ((count_reg != '0) && (n_sat != 3'd0))
                            begin
                                ids_next       = {match_id_d, match_id_c,
                                                  match_id_b, match_id_a};
                                n_next         = n_sat;
                                scan_ptr_next  = head_reg;
                                scan_left_next = count_reg;
                                state_next     = ST_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                res_status_next = STATUS_OK;
                res_handle_next = ram_rdata.handle;
                res_index_next  = ram_rdata.next_index;
                if (eval.last)
                begin
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - AW'(1);
                end
                else
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = head_reg;
                    ram_wdata.next_index = eval.next_inc;
                end
                state_next = ST_RESP;
            end

            ST_SCAN_RD:
            begin
                ram_raddr  = scan_ptr_reg;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                // The read port looks at the head here, ready for a refill.
                ram_raddr = head_reg;
                if (eval.hit)
                begin
                    res_status_next = STATUS_OK;
                    res_handle_next = ram_rdata.handle;
                    res_index_next  = ram_rdata.next_index;
                    if (eval.last)
                    begin
                        hit_slot_next = scan_ptr_reg;
                        state_next    = ST_REFILL;
                    end
                    else
                    begin
                        ram_we               = 1'b1;
                        ram_waddr            = scan_ptr_reg;
                        ram_wdata.next_index = eval.next_inc;
                        state_next           = ST_RESP;
                    end
                end
                else if (scan_left_reg == AW'(1))
                begin
                    res_status_next = STATUS_EMPTY;
                    state_next      = ST_RESP;
                end
                else
                begin
                    scan_ptr_next  = ptr_inc(scan_ptr_reg);
                    scan_left_next = scan_left_reg - AW'(1);
                    state_next     = ST_SCAN_RD;
                end
            end

            ST_REFILL:
            begin
                // Move the head entry into the exhausted slot and retire the head.
                ram_we     = 1'b1;
                ram_waddr  = hit_slot_reg;
                ram_wdata  = ram_rdata;
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - AW'(1);
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    handle_next    = res_handle_reg;
                    index_next     = res_index_reg;
                    used_next      = count_wide[5:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_handle   = handle_reg;
    assign work_index   = index_reg;
    assign entries_used = used_reg;

endmodule

// File: src/rtdq_checker.sv
// Port-level checker for the range task dispatch queue, bound to the top level.
// Depends on rtdq_pkg and range_task_dispatch_queue_core.
module rtdq_checker
    import rtdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [15:0] out_handle,
    input logic [31:0] work_index,
    input logic [5:0]  entries_used
);

    localparam logic [31:0] FULL_LEVEL = 32'(QUEUE_DEPTH - 1);

    // A stalled response transaction holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(work_index) && $stable(out_handle))
        else $error("response changed while stalled");

    // Each request occupies the sequencer, so the request side drops ready after a request transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request side ready right after a request transaction");

    // A refused push only happens at the full fill level.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_FULL) |-> entries_used == FULL_LEVEL[5:0])
        else $error("full status below full fill level");

    // Anything but a dispatch carries a zero handle and index.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STATUS_OK) |-> (out_handle == '0) && (work_index == '0))
        else $error("nonzero payload without a dispatch");

    // Only defined status codes are reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STATUS_OK) || (status == STATUS_EMPTY)
            || (status == STATUS_FULL))
        else $error("undefined status code");

endmodule

bind range_task_dispatch_queue_core rtdq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rtdq_checker (.*);
